// ----- rtl/core/msp_pkg.sv -----
// Shared types and constants for the motor speed PID step block.
// Depends on nothing; every other file of the block imports it.
package msp_pkg;

	localparam int SPEED_W   = 15;
	localparam int ERR_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int DRIVE_W   = 32;
	localparam int PROD_W    = 32;
	localparam int INTEG_W   = 17;
	localparam int CFG_IDX_W = 2;
	localparam int MS_PER_S  = 1000;

	// Number of stages of one constant scaling unit and width of its signed result.
	localparam int SCALE_STAGES = 5;
	localparam int SCALE_OW     = 44;

	// Input register, error stage, product stage, scaling stages,
	// integral stage and output register.
	localparam int PIPE_DEPTH = SCALE_STAGES + 5;

	localparam logic [GAIN_W-1:0] INT_LIMIT_RESET = 16'd7680;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_INT_LIMIT
	} msp_reg_e_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic        [GAIN_W-1:0] integral_limit;
	} msp_cfg_t;

endpackage

// ----- rtl/core/msp_if.sv -----
// Channel interfaces of the motor speed PID step block: input items,
// result items and configuration writes. Depends on msp_pkg.
interface msp_in_if import msp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [SPEED_W-1:0] target_speed;
	logic signed [SPEED_W-1:0] measured_speed;
	logic                      run_enable;

	modport source (output valid, output target_speed, output measured_speed,
		output run_enable, input ready);
	modport sink (input valid, input target_speed, input measured_speed,
		input run_enable, output ready);
endinterface

interface msp_out_if import msp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive_out;
	logic                      integral_clamped;

	modport source (output valid, output drive_out, output integral_clamped,
		input ready);
	modport sink (input valid, input drive_out, input integral_clamped,
		output ready);
endinterface

interface msp_cfg_if import msp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [GAIN_W-1:0]    wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/core/msp_scale.sv -----
// Pipelined constant scaler: y = round(x * MUL_K / DIV_K), halves away
// from zero, by reciprocal multiplication. Depends on msp_pkg.
module msp_scale import msp_pkg::*; #(
	parameter int MUL_K = 1,
	parameter int DIV_K = 1,
	parameter int IN_W  = 32,
	parameter int OUT_W = 44
) (
	input  logic                    clk,
	input  logic [SCALE_STAGES-1:0] en,
	input  logic signed [IN_W-1:0]  x,
	output logic signed [OUT_W-1:0] y
);

	// First division: |x| / DIV_K with an under-estimating reciprocal and
	// one correction step.
	localparam logic [IN_W:0] RECIP1 = (IN_W+1)'((65'd1 << IN_W) / DIV_K);
	localparam int R_W   = $clog2(2 * DIV_K + 1);
	localparam int HALF  = DIV_K / 2;
	localparam int V_W   = $clog2(DIV_K * (MUL_K + 1) + 1);
	// Second division is exact since v * DIV_K stays below 2**SH2.
	localparam int SH2   = $clog2(64'(DIV_K) * 64'(DIV_K) * 64'(MUL_K + 1));
	localparam logic [SH2:0] RECIP2 =
		(SH2+1)'(((64'd1 << SH2) + 64'(DIV_K) - 64'd1) / 64'(DIV_K));
	localparam int Q2_W  = $clog2(MUL_K + 1);
	localparam int MAG_W = OUT_W - 1;
	localparam int P2_W  = V_W + SH2 + 1;

	logic [IN_W-1:0]   mag_c;
	logic [2*IN_W:0]   prod1_c;
	logic [2*IN_W:0]   prod_s1;
	logic [IN_W-1:0]   mag_s1;
	logic              sgn_s1;

	logic [IN_W-1:0]   q_est_c;
	logic [IN_W-1:0]   qb_c;
	logic [R_W-1:0]    rem_c;
	logic [IN_W-1:0]   q_s2;
	logic [R_W-1:0]    r_s2;
	logic              sgn_s2;

	logic              fix_c;
	logic [IN_W-1:0]   q_fix_c;
	logic [R_W-1:0]    r_fix_c;
	logic [V_W-1:0]    v_c;
	logic [MAG_W-1:0]  qa_c;
	logic [V_W-1:0]    v_s3;
	logic [MAG_W-1:0]  qa_s3;
	logic              sgn_s3;

	logic [P2_W-1:0]   prod2_c;
	logic [P2_W-1:0]   prod2_s4;
	logic [MAG_W-1:0]  qa_s4;
	logic              sgn_s4;

	logic [Q2_W-1:0]   q2_c;
	logic [MAG_W-1:0]  magr_c;
	logic signed [OUT_W-1:0] res_c;
	logic signed [OUT_W-1:0] y_s5;

	assign mag_c   = x[IN_W-1] ? (~$unsigned(x)) + 1'b1 : $unsigned(x);
	assign prod1_c = (2*IN_W+1)'(mag_c) * (2*IN_W+1)'(RECIP1);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= prod1_c;
			mag_s1  <= mag_c;
			sgn_s1  <= x[IN_W-1];
		end
	end

	assign q_est_c = prod_s1[2*IN_W-1:IN_W];
	assign qb_c    = IN_W'(q_est_c * IN_W'(DIV_K));
	assign rem_c   = R_W'(mag_s1 - qb_c);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			q_s2   <= q_est_c;
			r_s2   <= rem_c;
			sgn_s2 <= sgn_s1;
		end
	end

	assign fix_c   = r_s2 >= R_W'(DIV_K);
	assign q_fix_c = q_s2 + IN_W'(fix_c);
	assign r_fix_c = fix_c ? r_s2 - R_W'(DIV_K) : r_s2;
	assign v_c     = V_W'(r_fix_c) * V_W'(MUL_K) + V_W'(HALF);
	assign qa_c    = MAG_W'(q_fix_c) * MAG_W'(MUL_K);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			v_s3   <= v_c;
			qa_s3  <= qa_c;
			sgn_s3 <= sgn_s2;
		end
	end

	assign prod2_c = P2_W'(v_s3) * P2_W'(RECIP2);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			prod2_s4 <= prod2_c;
			qa_s4    <= qa_s3;
			sgn_s4   <= sgn_s3;
		end
	end

	assign q2_c   = prod2_s4[SH2 +: Q2_W];
	assign magr_c = qa_s4 + MAG_W'(q2_c);
	assign res_c  = sgn_s4 ? -$signed({1'b0, magr_c}) : $signed({1'b0, magr_c});

	always_ff @(posedge clk) begin
		if (en[4]) begin
			y_s5 <= res_c;
		end
	end

	assign y = y_s5;

endmodule

// ----- rtl/core/msp_regs.sv -----
// Configuration register file of the motor speed PID step block.
// Depends on msp_pkg and the msp_cfg_if interface.
module msp_regs import msp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	msp_cfg_if.sink   cfg,
	output msp_cfg_t  regs
);

	msp_cfg_t cfg_q;

	// Writes always complete in the cycle they are offered.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= '0;
			cfg_q.gain_i         <= '0;
			cfg_q.gain_d         <= '0;
			cfg_q.integral_limit <= INT_LIMIT_RESET;
		end else if (cfg.valid) begin
			case (msp_reg_e_t'(cfg.index))
				REG_GAIN_P:    cfg_q.gain_p         <= $signed(cfg.wdata);
				REG_GAIN_I:    cfg_q.gain_i         <= $signed(cfg.wdata);
				REG_GAIN_D:    cfg_q.gain_d         <= $signed(cfg.wdata);
				REG_INT_LIMIT: cfg_q.integral_limit <= cfg.wdata;
				default: begin
				end
			endcase
		end
	end

	assign regs = cfg_q;

endmodule

// ----- rtl/core/motor_speed_pid_step.sv -----
// Top level of the motor speed PID step block: elastic ten-stage pipeline.
// Depends on msp_pkg, the interfaces in msp_if, msp_regs and msp_scale.
//
// One control tick enters per cycle unless a stalled output has backed up
// to the input register; its result passes through the PIPE_DEPTH stages
// (input register, error, products, five stages of constant scaling,
// integral update, output register). Two feedback paths set the rate, the
// prior-error subtract in the error stage and the integral add and clamp
// in the integral stage; everything else is feed-forward. Each stage
// holds its item until the next stage is free, so the block keeps taking
// ticks into empty stages while a finished result waits at the output,
// and up to ten ticks can be in flight. Configuration writes complete in
// the cycle they are offered and must only be issued while the pipeline
// is empty. Gains are signed Q8.8, the drive command is signed Q24.8 and
// saturates at the 32-bit range; the integral term is held within plus
// or minus integral_limit. A tick with run_enable low yields a zero
// command and leaves the controller state alone; a running tick with a
// zero target yields a zero command and clears the integral term.
module motor_speed_pid_step import msp_pkg::*; #(
	parameter int INTERVAL_MS = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	msp_in_if.sink      sample,
	msp_out_if.source   result,
	msp_cfg_if.sink     cfg
);

	localparam int S8    = SCALE_STAGES + 2;
	localparam int S9    = SCALE_STAGES + 3;
	localparam int S10   = SCALE_STAGES + 4;
	localparam int SUM_W = SCALE_OW + 2;

	// Saturation bounds of the drive command in the width of the sum.
	localparam logic signed [SUM_W-1:0] SAT_HI =
		$signed({{(SUM_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	msp_cfg_t cfg_regs;

	logic [PIPE_DEPTH-1:0] stage_en;
	logic [PIPE_DEPTH-1:0] stage_vld_q;

	logic signed [SPEED_W-1:0] tgt_s1;
	logic signed [SPEED_W-1:0] meas_s1;
	logic                      run_s1;

	logic signed [ERR_W-1:0] err_c;
	logic signed [ERR_W:0]   dlt_c;
	logic signed [ERR_W-1:0] prior_err_q;
	logic signed [ERR_W-1:0] err_s2;
	logic signed [ERR_W:0]   dlt_s2;
	logic                    run_s2;
	logic                    zero_s2;

	logic signed [PROD_W-1:0] pp_s3;
	logic signed [PROD_W-1:0] pi_s3;
	logic signed [PROD_W-1:0] pd_s3;
	logic                     run_s3;
	logic                     zero_s3;

	logic signed [PROD_W-1:0] pp_dly_q   [SCALE_STAGES];
	logic                     run_dly_q  [SCALE_STAGES];
	logic                     zero_dly_q [SCALE_STAGES];

	logic signed [SCALE_OW-1:0] i_inc;
	logic signed [SCALE_OW-1:0] d_term;

	logic signed [INTEG_W-1:0] integral_q;
	logic signed [INTEG_W+15:0] integ_sum_c;
	logic signed [INTEG_W+15:0] lim_c;
	logic                       over_c;
	logic                       under_c;
	logic signed [INTEG_W-1:0]  integ_c;

	logic signed [INTEG_W-1:0]  integ_s9;
	logic                       clamp_s9;
	logic signed [PROD_W-1:0]   pp_s9;
	logic signed [SCALE_OW-1:0] d_s9;
	logic                       live_s9;

	logic signed [SUM_W-1:0]   sum_c;
	logic signed [DRIVE_W-1:0] sat_c;
	logic signed [DRIVE_W-1:0] drive_s10;
	logic                      clamp_s10;

	msp_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	// A stage may load when it is empty or when its item moves on. The
	// chain runs back from the output register.
	always_comb begin
		stage_en[PIPE_DEPTH-1] = !stage_vld_q[PIPE_DEPTH-1] || result.ready;
		for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
			stage_en[k] = !stage_vld_q[k] || stage_en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				stage_vld_q[0] <= sample.valid;
			end
			for (int k = 1; k < PIPE_DEPTH; k++) begin
				if (stage_en[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	assign sample.ready = stage_en[0];

	// Input register.
	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			tgt_s1  <= sample.target_speed;
			meas_s1 <= sample.measured_speed;
			run_s1  <= sample.run_enable;
		end
	end

	// Error stage. The prior error is the error of the last running tick,
	// taken in tick order as items leave the input register.
	assign err_c = ERR_W'(tgt_s1) - ERR_W'(meas_s1);
	assign dlt_c = (ERR_W+1)'(err_c) - (ERR_W+1)'(prior_err_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_err_q <= '0;
		end else if (stage_en[1] && stage_vld_q[0] && run_s1) begin
			prior_err_q <= err_c;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			err_s2  <= err_c;
			dlt_s2  <= dlt_c;
			run_s2  <= run_s1;
			zero_s2 <= tgt_s1 == '0;
		end
	end

	// Product stage: the three gain multiplies, each exact in 32 bits.
	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			pp_s3   <= PROD_W'(cfg_regs.gain_p) * PROD_W'(err_s2);
			pi_s3   <= PROD_W'(cfg_regs.gain_i) * PROD_W'(err_s2);
			pd_s3   <= PROD_W'(cfg_regs.gain_d) * PROD_W'(dlt_s2);
			run_s3  <= run_s2;
			zero_s3 <= zero_s2;
		end
	end

	// Time scaling of the integral increment (times dt) and of the
	// derivative (divided by dt), both rounded half away from zero.
	msp_scale #(
		.MUL_K (INTERVAL_MS),
		.DIV_K (MS_PER_S),
		.IN_W  (PROD_W),
		.OUT_W (SCALE_OW)
	) u_scale_i (
		.clk (clk),
		.en  (stage_en[3 +: SCALE_STAGES]),
		.x   (pi_s3),
		.y   (i_inc)
	);

	msp_scale #(
		.MUL_K (MS_PER_S),
		.DIV_K (INTERVAL_MS),
		.IN_W  (PROD_W),
		.OUT_W (SCALE_OW)
	) u_scale_d (
		.clk (clk),
		.en  (stage_en[3 +: SCALE_STAGES]),
		.x   (pd_s3),
		.y   (d_term)
	);

	// The proportional term and the tick flags ride alongside the scalers.
	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			pp_dly_q[0]   <= pp_s3;
			run_dly_q[0]  <= run_s3;
			zero_dly_q[0] <= zero_s3;
		end
		for (int k = 1; k < SCALE_STAGES; k++) begin
			if (stage_en[3+k]) begin
				pp_dly_q[k]   <= pp_dly_q[k-1];
				run_dly_q[k]  <= run_dly_q[k-1];
				zero_dly_q[k] <= zero_dly_q[k-1];
			end
		end
	end

	// Integral stage: accumulate and clamp. Landing exactly on the limit
	// does not count as a clamp.
	assign integ_sum_c = (INTEG_W+16)'(integral_q) + (INTEG_W+16)'(i_inc);
	assign lim_c       = $signed({{INTEG_W{1'b0}}, cfg_regs.integral_limit});
	assign over_c      = integ_sum_c > lim_c;
	assign under_c     = integ_sum_c < -lim_c;
	assign integ_c     = over_c  ? INTEG_W'(lim_c) :
	                     under_c ? INTEG_W'(-lim_c) : INTEG_W'(integ_sum_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
		end else if (stage_en[S9] && stage_vld_q[S8] && run_dly_q[SCALE_STAGES-1]) begin
			// A zero target clears the integral after the tick is computed.
			integral_q <= zero_dly_q[SCALE_STAGES-1] ? '0 : integ_c;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[S9]) begin
			integ_s9 <= integ_c;
			clamp_s9 <= over_c || under_c;
			pp_s9    <= pp_dly_q[SCALE_STAGES-1];
			d_s9     <= d_term;
			live_s9  <= run_dly_q[SCALE_STAGES-1] && !zero_dly_q[SCALE_STAGES-1];
		end
	end

	// Output register: sum, saturate, and force zero for stopped and zero-target ticks.
	assign sum_c = SUM_W'(pp_s9) + SUM_W'(integ_s9) + SUM_W'(d_s9);
	assign sat_c = (sum_c > SAT_HI) ? DRIVE_W'(SAT_HI) :
	               (sum_c < SAT_LO) ? DRIVE_W'(SAT_LO) : DRIVE_W'(sum_c);

	always_ff @(posedge clk) begin
		if (stage_en[S10]) begin
			drive_s10 <= live_s9 ? sat_c : '0;
			clamp_s10 <= live_s9 && clamp_s9;
		end
	end

	assign result.valid            = stage_vld_q[S10];
	assign result.drive_out        = drive_s10;
	assign result.integral_clamped = clamp_s10;

endmodule

// ----- rtl/core/msp_chk.sv -----
// Port-level checker for the motor speed PID step block, bound to its top
// level. Depends on msp_pkg.
module msp_chk import msp_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      sample_valid,
	input logic                      sample_ready,
	input logic                      result_valid,
	input logic                      result_ready,
	input logic signed [DRIVE_W-1:0] drive_out,
	input logic                      integral_clamped,
	input logic                      cfg_ready
);

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic [CNT_W-1:0] pend_q;
	logic             in_xfer;
	logic             out_xfer;

	assign in_xfer  = sample_valid && sample_ready;
	assign out_xfer = result_valid && result_ready;

	// Ticks taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + CNT_W'(in_xfer) - CNT_W'(out_xfer);
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(drive_out) && $stable(integral_clamped))
		else $error("result payload changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != '0)
		else $error("result offered with no tick outstanding");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CNT_W'(PIPE_DEPTH))
		else $error("more ticks in flight than pipeline stages");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration write not taken at once");

endmodule

bind motor_speed_pid_step msp_chk u_msp_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.sample_valid     (sample.valid),
	.sample_ready     (sample.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.drive_out        (result.drive_out),
	.integral_clamped (result.integral_clamped),
	.cfg_ready        (cfg.ready)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the motor speed PID step block: directed ticks, then random phases.
// Depends on msp_pkg, the channel interfaces in msp_if and the motor_speed_pid_step top level.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import msp_pkg::*;

	localparam int INTERVAL_MS = 200;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_PHASES = 11;
	localparam int PHASE_TICKS = 48;
	localparam longint DRIVE_MAX = 64'sd2147483647;
	localparam longint DRIVE_MIN = -64'sd2147483648;

	// One expected result of a control tick.
	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		logic                      clamped;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n;

	msp_in_if  sample_ch ();
	msp_out_if result_ch ();
	msp_cfg_if cfg_ch ();

	motor_speed_pid_step #(.INTERVAL_MS(INTERVAL_MS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Our own copy of the register file and the controller state. It starts at the
	// reset values of the block and follows every register write and every tick.
	logic signed [GAIN_W-1:0] kp = '0;
	logic signed [GAIN_W-1:0] ki = '0;
	logic signed [GAIN_W-1:0] kd = '0;
	logic        [GAIN_W-1:0] integ_limit = INT_LIMIT_RESET;
	logic signed [ERR_W-1:0]  last_error = '0;
	logic signed [31:0]       integ_acc = '0;

	tick_result_t expected_results[$];

	int  errors = 0;
	int  cycle_count = 0;
	int  n_ticks = 0;
	int  n_settings = 0;
	int  n_clamped = 0;
	int  n_idle = 0;
	int  n_zero_target = 0;
	bit  calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Rounds num/den to the nearest integer with halves going away from zero; den > 0.
	function automatic longint div_nearest(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	// Computes the result of one accepted tick and advances the controller state.
	function automatic tick_result_t predict_tick(input logic signed [SPEED_W-1:0] tgt,
		input logic signed [SPEED_W-1:0] meas, input logic run);
		tick_result_t r;
		longint err;
		longint acc;
		longint lim;
		longint prop;
		longint deriv;
		longint total;
		r.drive = '0;
		r.clamped = 1'b0;
		if (!run) begin
			// A stopped controller commands nothing and keeps its history.
			n_idle++;
			return r;
		end
		err = longint'(tgt) - longint'(meas);
		acc = longint'(integ_acc) +
			div_nearest(longint'(ki) * err * INTERVAL_MS, MS_PER_S);
		lim = longint'(integ_limit);
		// Landing exactly on the bound is allowed and does not count as a clamp.
		if (acc > lim) begin
			acc = lim;
			r.clamped = 1'b1;
		end else if (acc < -lim) begin
			acc = -lim;
			r.clamped = 1'b1;
		end
		prop = longint'(kp) * err;
		deriv = div_nearest(longint'(kd) * (err - longint'(last_error)) * MS_PER_S,
			INTERVAL_MS);
		total = prop + acc + deriv;
		if (total > DRIVE_MAX) total = DRIVE_MAX;
		if (total < DRIVE_MIN) total = DRIVE_MIN;
		last_error = err[ERR_W-1:0];
		integ_acc = acc[31:0];
		r.drive = total[DRIVE_W-1:0];
		// A zero target still records the error, but it wipes the integral
		// and forces the command and the clamp flag to zero.
		if (tgt == 0) begin
			integ_acc = '0;
			r.drive = '0;
			r.clamped = 1'b0;
			n_zero_target++;
		end
		if (r.clamped) n_clamped++;
		return r;
	endfunction

	// Offers one tick and waits for its transfer. Valid is only lowered ahead of a
	// gap, so back-to-back ticks keep valid high without a second assignment.
	task automatic send_tick(input logic signed [SPEED_W-1:0] tgt,
		input logic signed [SPEED_W-1:0] meas, input logic run);
		if (!calm && $urandom_range(0, 5) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.target_speed <= tgt;
		sample_ch.measured_speed <= meas;
		sample_ch.run_enable <= run;
		do @(posedge clk); while (!sample_ch.ready);
		expected_results.push_back(predict_tick(tgt, meas, run));
		n_ticks++;
	endtask

	// Stops sending and waits until every outstanding result has been checked.
	// The queue is looked at on the falling edge, away from the checker's updates.
	task automatic wait_until_drained();
		sample_ch.valid <= 1'b0;
		do @(negedge clk); while (expected_results.size() != 0);
		@(posedge clk);
	endtask

	// One register write; only called with the pipeline empty.
	task automatic set_reg(input msp_reg_e_t idx, input logic [GAIN_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_GAIN_P: kp = value;
			REG_GAIN_I: ki = value;
			REG_GAIN_D: kd = value;
			REG_INT_LIMIT: integ_limit = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
		input logic [GAIN_W-1:0] d, input logic [GAIN_W-1:0] lim);
		wait_until_drained();
		set_reg(REG_GAIN_P, p);
		set_reg(REG_GAIN_I, i);
		set_reg(REG_GAIN_D, d);
		set_reg(REG_INT_LIMIT, lim);
		n_settings++;
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 3))
			0: return GAIN_W'($urandom);
			1: return GAIN_W'(int'($urandom_range(0, 2047)) - 1024);
			2: return GAIN_W'(int'($urandom_range(0, 31)) - 16);
			default: return '0;
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_limit();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return GAIN_W'($urandom_range(0, 2000));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// Sink side: the result channel stalls in bursts, except near the end of the run.
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// Every transfer on the result channel is matched against the oldest expectation.
	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t ns: result with nothing expected, drive_out %0d clamped %0b",
					$time, result_ch.drive_out, result_ch.integral_clamped);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (result_ch.drive_out !== want.drive) begin
					$display("%0t ns: drive_out expected %0d actual %0d",
						$time, want.drive, result_ch.drive_out);
					errors++;
				end
				if (result_ch.integral_clamped !== want.clamped) begin
					$display("%0t ns: integral_clamped expected %0b actual %0b",
						$time, want.clamped, result_ch.integral_clamped);
					errors++;
				end
			end
		end
	end

	// With only the integral gain written, the integral bound must still be the
	// reset value of 30.0, and the extreme inputs push it into both sides.
	task automatic test_reset_values();
		set_reg(REG_GAIN_I, 16'h7FFF);
		send_tick(15'sh3FFF, 15'sh4000, 1'b1);
		send_tick(15'sh4000, 15'sh3FFF, 1'b1);
	endtask

	// Largest gains of both signs with the largest error: the sum saturates.
	task automatic test_saturation();
		configure(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
		send_tick(15'sh3FFF, 15'sh4000, 1'b1);
		send_tick(15'sh4000, 15'sh3FFF, 1'b1);
		send_tick(15'sh0000, 15'sh0000, 1'b0);
		configure(16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
		send_tick(15'sh3FFF, 15'sh4000, 1'b1);
		send_tick(15'sh4000, 15'sh3FFF, 1'b1);
	endtask

	// With an integral gain of 5 the increment equals the error, which makes it
	// easy to come close to the upper bound, cross the lower one, and then lower
	// the bound under a stored integral that only the next running tick clamps.
	task automatic test_integral_clamp();
		configure(16'h0000, 16'h0005, 16'h0000, 16'd100);
		send_tick(15'sd0, 15'sd7, 1'b1);
		send_tick(15'sd100, 15'sd0, 1'b1);
		send_tick(15'sd1, 15'sd0, 1'b1);
		send_tick(-15'sd250, 15'sd0, 1'b1);
		wait_until_drained();
		set_reg(REG_INT_LIMIT, 16'd50);
		send_tick(15'sd5, 15'sd5, 1'b0);
		send_tick(15'sd10, 15'sd0, 1'b1);
		// Rounding of small increments of both signs.
		configure(16'h0000, 16'h0001, 16'h0000, 16'hFFFF);
		send_tick(15'sd0, 15'sd0, 1'b1);
		send_tick(15'sd3, 15'sd0, 1'b1);
		send_tick(-15'sd3, 15'sd0, 1'b1);
		send_tick(-15'sd2, 15'sd0, 1'b1);
	endtask

	// A zero target clears the integral and hides a clamp, but its error still
	// feeds the derivative of the following tick.
	task automatic test_zero_target();
		configure(16'd256, 16'd256, 16'd256, 16'd10);
		send_tick(15'sd1000, 15'sd0, 1'b1);
		send_tick(15'sd0, 15'sd500, 1'b1);
		send_tick(15'sd300, 15'sd0, 1'b1);
	endtask

	// A stopped tick outputs zero and the next running tick sees the old state.
	task automatic test_not_running();
		send_tick(15'sd1000, -15'sd1000, 1'b0);
		send_tick(15'sd200, 15'sd100, 1'b1);
	endtask

	// Random phases, each under its own register setting. On average 44 ticks in 100
	// run with an error small enough to keep the integral and the sum inside their ranges.
	task automatic test_random_settings();
		logic signed [SPEED_W-1:0] tgt;
		logic signed [SPEED_W-1:0] meas;
		logic run;
		int kind;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == RAND_PHASES - 2) calm = 1'b1;
			case (ph)
				0: configure(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
				1: configure(16'h8000, 16'h8000, 16'h8000, 16'h0000);
				default: configure(pick_gain(), pick_gain(), pick_gain(), pick_limit());
			endcase
			repeat (PHASE_TICKS) begin
				kind = $urandom_range(0, 99);
				tgt = SPEED_W'($urandom);
				meas = SPEED_W'($urandom);
				run = 1'b1;
				if (kind < 8) begin
					run = 1'b0;
				end else if (kind < 16) begin
					tgt = '0;
				end else if (kind < 60) begin
					meas = SPEED_W'(int'(tgt) + int'($urandom_range(0, 400)) - 200);
				end
				send_tick(tgt, meas, run);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.target_speed <= '0;
		sample_ch.measured_speed <= '0;
		sample_ch.run_enable <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_GAIN_P;
		cfg_ch.wdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_saturation();
		test_integral_clamp();
		test_zero_target();
		test_not_running();
		test_random_settings();

		// Let the pipeline run empty and watch for stray results a while longer.
		wait_until_drained();
		repeat (3 * PIPE_DEPTH) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t ns: %0d expected results never arrived",
				$time, expected_results.size());
			errors++;
		end

		$display("Sent %0d ticks under %0d register settings: %0d clamped the integral,",
			n_ticks, n_settings, n_clamped);
		$display("%0d were stopped ticks and %0d running ticks had a zero target; %0d errors.",
			n_idle, n_zero_target, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog on the cycle counter in case a transfer never completes.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t ns: run stopped after %0d cycles with %0d results outstanding",
			$time, cycle_count, expected_results.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
